@@ rtl/sca_pkg.sv @@
// Package for the spectral channel averager: widths, register indexes,
// controller state and the command/status structs shared by the core, controller and datapath.
// No dependencies.
`default_nettype none

package sca_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_CHANNELS   = 4096;
   localparam int CHAN_BITS      = $clog2(MAX_CHANNELS);
   localparam int NEW_BITS       = CHAN_BITS + 1;
   localparam int FACTOR_BITS    = 12;
   localparam int SUM_BITS       = SAMPLE_BITS + FACTOR_BITS;
   localparam int DIV_CNT_BITS   = $clog2(SUM_BITS);
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FACTOR        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_CHANNEL = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEW_CHANNELS  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } sca_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic load_out;
   } sca_cmd_type;

   typedef struct packed {
      logic ch0_hit;
      logic grp_done;
      logic div_last;
   } sca_status_type;

endpackage

`default_nettype wire

@@ rtl/sca_if.sv @@
// Handshake interfaces for the sample input channel and the result channel.
// Depends on sca_pkg for field widths.
`default_nettype none

interface sca_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [sca_pkg::SAMPLE_BITS-1:0]    sample_re;
   logic signed [sca_pkg::SAMPLE_BITS-1:0]    sample_im;
   logic                                      sample_flag;
   logic                                      spectrum_end;

   modport source (output valid, sample_re, sample_im, sample_flag, spectrum_end,
                   input ready);
   modport sink   (input valid, sample_re, sample_im, sample_flag, spectrum_end,
                   output ready);
endinterface

interface sca_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic        [sca_pkg::CHAN_BITS-1:0]      out_channel;
   logic signed [sca_pkg::SAMPLE_BITS-1:0]    avg_re;
   logic signed [sca_pkg::SAMPLE_BITS-1:0]    avg_im;
   logic                                      avg_flag;
   logic                                      out_last;

   modport source (output valid, out_channel, avg_re, avg_im, avg_flag, out_last,
                   input ready);
   modport sink   (input valid, out_channel, avg_re, avg_im, avg_flag, out_last,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/spectral_channel_averager_core.sv @@
// A channel 0 word goes from acceptance through the EMIT state to the result
// load; a word that closes a group first runs the divider steps in DIV. The load
// waits while the result register still holds an unaccepted word.
// A word that yields no result leaves the core in IDLE, ready for the next word; after
// a channel 0 or group-closing word no word is taken until its result is loaded.
// Reset (synchronous): factor, first_channel and new_channels return to 1, all
// spectrum counters and sums clear, no result is pending.
`default_nettype none

module spectral_channel_averager_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sca_req_if.sink                                 req_if,
   sca_rsp_if.source                               rsp_if,
   input  wire logic                               csr_write,
   input  wire logic [sca_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sca_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import sca_pkg::*;

   sca_cmd_type    cmd;
   sca_status_type status;

   sca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sca_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .sample_re    (req_if.sample_re),
      .sample_im    (req_if.sample_im),
      .sample_flag  (req_if.sample_flag),
      .spectrum_end (req_if.spectrum_end),
      .cmd          (cmd),
      .status       (status),
      .out_channel  (rsp_if.out_channel),
      .avg_re       (rsp_if.avg_re),
      .avg_im       (rsp_if.avg_im),
      .avg_flag     (rsp_if.avg_flag),
      .out_last     (rsp_if.out_last)
   );

   a_group_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.grp_done |=> !req_if.ready && cmd.div_step)
      else $error("closing word did not start the divider");

   a_ch0_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.ch0_hit |=> !req_if.ready && !cmd.div_step)
      else $error("channel zero word did not go straight to result load");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_if.valid)
      else $error("result load did not raise valid");

endmodule

`default_nettype wire

@@ rtl/sca_ctrl.sv @@
// Controller state machine: accepts words, sequences the divider steps and
// loads the result register. Depends on sca_pkg.
`default_nettype none

module sca_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire sca_pkg::sca_status_type status,
   output sca_pkg::sca_cmd_type         cmd
);
   import sca_pkg::*;

   sca_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.ch0_hit) begin
                  state_in = ST_EMIT;
               end else if (status.grp_done) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.load_out = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

@@ rtl/sca_datapath.sv @@
// Datapath: configuration registers, spectrum counters, group accumulators,
// bit-serial restoring divider and result register. Depends on sca_pkg.
`default_nettype none

module sca_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [sca_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [sca_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  wire logic signed [sca_pkg::SAMPLE_BITS-1:0] sample_re,
   input  wire logic signed [sca_pkg::SAMPLE_BITS-1:0] sample_im,
   input  wire logic                                  sample_flag,
   input  wire logic                                  spectrum_end,
   input  wire sca_pkg::sca_cmd_type                  cmd,
   output sca_pkg::sca_status_type                    status,
   output logic [sca_pkg::CHAN_BITS-1:0]              out_channel,
   output logic signed [sca_pkg::SAMPLE_BITS-1:0]     avg_re,
   output logic signed [sca_pkg::SAMPLE_BITS-1:0]     avg_im,
   output logic                                       avg_flag,
   output logic                                       out_last
);
   import sca_pkg::*;

   localparam logic [NEW_BITS-1:0]  LIMIT_MAX = NEW_BITS'(MAX_CHANNELS);
   localparam logic [CHAN_BITS-1:0] OLD_MAX   = CHAN_BITS'(MAX_CHANNELS - 1);
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(SUM_BITS - 1);

   logic [FACTOR_BITS-1:0]   factor_ff;
   logic [CHAN_BITS-1:0]     first_ff;
   logic [NEW_BITS-1:0]      newch_ff;

   logic [CHAN_BITS-1:0]     old_index_ff;
   logic [FACTOR_BITS-1:0]   group_count_ff;
   logic signed [SUM_BITS-1:0] sum_re_ff;
   logic signed [SUM_BITS-1:0] sum_im_ff;
   logic                     flag_or_ff;
   logic [NEW_BITS-1:0]      new_index_ff;

   logic [SUM_BITS-1:0]      dvd_re_ff, dvd_im_ff, dvd_re_in, dvd_im_in;
   logic [FACTOR_BITS-1:0]   rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic                     neg_re_ff, neg_im_ff;
   logic [DIV_CNT_BITS-1:0]  div_cnt_ff;
   logic [CHAN_BITS-1:0]     res_chan_ff;
   logic                     res_flag_ff;
   logic                     res_last_ff;

   logic [CHAN_BITS-1:0]     out_channel_ff;
   logic [SAMPLE_BITS-1:0]   avg_re_ff, avg_im_ff;
   logic                     avg_flag_ff, out_last_ff;

   logic [FACTOR_BITS-1:0]   fct;
   logic [CHAN_BITS-1:0]     start;
   logic [NEW_BITS-1:0]      limit;
   logic                     active, in_group, ch0_hit, grp_done;
   logic signed [SUM_BITS-1:0] sum_re_nx, sum_im_nx;
   logic [FACTOR_BITS-1:0]   gc_nx;
   logic                     grp_last;
   logic [FACTOR_BITS:0]     trial_re, trial_im;
   logic                     ge_re, ge_im;
   logic [SUM_BITS-1:0]      q_re, q_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_BITS'(1);
         first_ff  <= CHAN_BITS'(1);
         newch_ff  <= NEW_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FACTOR:        factor_ff <= csr_data[FACTOR_BITS-1:0];
            CSR_FIRST_CHANNEL: first_ff  <= csr_data[CHAN_BITS-1:0];
            CSR_NEW_CHANNELS:  newch_ff  <= csr_data[NEW_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign fct   = (factor_ff == '0) ? FACTOR_BITS'(1) : factor_ff;
   assign start = (first_ff == '0) ? CHAN_BITS'(1) : first_ff;
   assign limit = (newch_ff > LIMIT_MAX) ? LIMIT_MAX : newch_ff;

   assign active    = new_index_ff < limit;
   assign ch0_hit   = active && (old_index_ff == '0);
   assign in_group  = active && (old_index_ff >= start);
   assign sum_re_nx = sum_re_ff + SUM_BITS'(sample_re);
   assign sum_im_nx = sum_im_ff + SUM_BITS'(sample_im);
   assign gc_nx     = group_count_ff + FACTOR_BITS'(1);
   assign grp_done  = in_group && (gc_nx >= fct);
   assign grp_last  = spectrum_end || ((new_index_ff + NEW_BITS'(1)) == limit);

   assign status.ch0_hit  = ch0_hit;
   assign status.grp_done = grp_done;
   assign status.div_last = div_cnt_ff == DIV_LAST;

   always_ff @(posedge clock) begin
      if (reset) begin
         old_index_ff   <= '0;
         group_count_ff <= '0;
         sum_re_ff      <= '0;
         sum_im_ff      <= '0;
         flag_or_ff     <= 1'b0;
         new_index_ff   <= '0;
      end else if (cmd.accept) begin
         if (spectrum_end) begin
            old_index_ff   <= '0;
            group_count_ff <= '0;
            sum_re_ff      <= '0;
            sum_im_ff      <= '0;
            flag_or_ff     <= 1'b0;
            new_index_ff   <= '0;
         end else begin
            if (old_index_ff != OLD_MAX) begin
               old_index_ff <= old_index_ff + CHAN_BITS'(1);
            end
            if (ch0_hit) begin
               new_index_ff <= NEW_BITS'(1);
            end else if (grp_done) begin
               group_count_ff <= '0;
               sum_re_ff      <= '0;
               sum_im_ff      <= '0;
               flag_or_ff     <= 1'b0;
               new_index_ff   <= new_index_ff + NEW_BITS'(1);
            end else if (in_group) begin
               group_count_ff <= gc_nx;
               sum_re_ff      <= sum_re_nx;
               sum_im_ff      <= sum_im_nx;
               flag_or_ff     <= flag_or_ff | sample_flag;
            end
         end
      end
   end

   // one quotient bit per step; dividend register collects the quotient
   always_comb begin
      trial_re  = {rem_re_ff, dvd_re_ff[SUM_BITS-1]};
      trial_im  = {rem_im_ff, dvd_im_ff[SUM_BITS-1]};
      ge_re     = trial_re >= {1'b0, fct};
      ge_im     = trial_im >= {1'b0, fct};
      rem_re_in = ge_re ? FACTOR_BITS'(trial_re - {1'b0, fct}) : trial_re[FACTOR_BITS-1:0];
      rem_im_in = ge_im ? FACTOR_BITS'(trial_im - {1'b0, fct}) : trial_im[FACTOR_BITS-1:0];
      dvd_re_in = {dvd_re_ff[SUM_BITS-2:0], ge_re};
      dvd_im_in = {dvd_im_ff[SUM_BITS-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.accept) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && ch0_hit) begin
         dvd_re_ff   <= '0;
         dvd_im_ff   <= '0;
         neg_re_ff   <= 1'b0;
         neg_im_ff   <= 1'b0;
         res_chan_ff <= '0;
         res_flag_ff <= 1'b1;
         res_last_ff <= spectrum_end || (limit == NEW_BITS'(1));
      end else if (cmd.accept && grp_done) begin
         dvd_re_ff   <= sum_re_nx[SUM_BITS-1] ? SUM_BITS'(-sum_re_nx) : SUM_BITS'(sum_re_nx);
         dvd_im_ff   <= sum_im_nx[SUM_BITS-1] ? SUM_BITS'(-sum_im_nx) : SUM_BITS'(sum_im_nx);
         neg_re_ff   <= sum_re_nx[SUM_BITS-1];
         neg_im_ff   <= sum_im_nx[SUM_BITS-1];
         rem_re_ff   <= '0;
         rem_im_ff   <= '0;
         res_chan_ff <= new_index_ff[CHAN_BITS-1:0];
         res_flag_ff <= flag_or_ff | sample_flag;
         res_last_ff <= grp_last;
      end else if (cmd.div_step) begin
         dvd_re_ff <= dvd_re_in;
         dvd_im_ff <= dvd_im_in;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
      end
   end

   assign q_re = neg_re_ff ? (~dvd_re_ff + SUM_BITS'(1)) : dvd_re_ff;
   assign q_im = neg_im_ff ? (~dvd_im_ff + SUM_BITS'(1)) : dvd_im_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_channel_ff <= res_chan_ff;
         avg_re_ff      <= q_re[SAMPLE_BITS-1:0];
         avg_im_ff      <= q_im[SAMPLE_BITS-1:0];
         avg_flag_ff    <= res_flag_ff;
         out_last_ff    <= res_last_ff;
      end
   end

   assign out_channel = out_channel_ff;
   assign avg_re      = avg_re_ff;
   assign avg_im      = avg_im_ff;
   assign avg_flag    = avg_flag_ff;
   assign out_last    = out_last_ff;

endmodule

`default_nettype wire
